FILE: hdl/nns_pkg.sv
// ----------------------------------------------------------------------------
// nns_pkg
// Shared types and constants of the nearest node search block: item
// formats, command word, register indexes and the axis distance helper.
// ----------------------------------------------------------------------------
package nns_pkg;

    localparam int COORD_BITS = 24;
    localparam int SLOT_W     = 10;
    localparam int IDX_W      = 10;
    localparam int DIST_W     = 52;
    localparam int DIMS_W     = 2;
    localparam int COUNT_W    = 11;
    localparam int SQ_W       = 2 * COORD_BITS;
    // three squares of at most 2^(2*COORD_BITS) each
    localparam int SUM_W      = 2 * COORD_BITS + 2;
    localparam int AXES       = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [DIMS_W-1:0]  DIMS_RESET  = 2'd3;
    localparam logic [COUNT_W-1:0] COUNT_RESET = '0;

    typedef enum logic [0:0] {
        KIND_LOAD  = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIMENSIONS = 2'd0,
        REG_NODE_COUNT = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic                         kind;
        logic [SLOT_W-1:0]            node_slot;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic signed [COORD_BITS-1:0] coord_z;
    } in_item_t;

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  nearest_index;
        logic [DIST_W-1:0] squared_distance;
    } out_item_t;

    // classified command passed from the front to the back
    typedef struct packed {
        logic                  is_query;
        logic [SLOT_W-1:0]     node_slot;
        logic [COORD_BITS-1:0] coord_x;
        logic [COORD_BITS-1:0] coord_y;
        logic [COORD_BITS-1:0] coord_z;
    } cmd_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
    } node_t;

    // |a - b| of two signed coordinates, always fits COORD_BITS unsigned bits
    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        logic [COORD_BITS:0] d;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        if (d[COORD_BITS]) begin
            d = (~d) + 1'b1;
        end
        return d[COORD_BITS-1:0];
    endfunction

endpackage

FILE: hdl/nns_front.sv
// ----------------------------------------------------------------------------
// nns_front
// Input stage: takes items, drops loads aimed beyond the node store and
// hands the rest on as commands.
// ----------------------------------------------------------------------------
module nns_front #(
    parameter int MAX_NODES = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  nns_pkg::in_item_t  s_data,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output nns_pkg::cmd_t      cmd_data
);

    logic          stage_valid_reg;
    nns_pkg::cmd_t stage_reg;
    logic          keep;

    assign keep = (s_data.kind == nns_pkg::KIND_QUERY) || (int'(s_data.node_slot) < MAX_NODES);

    assign s_ready   = !stage_valid_reg || cmd_ready;
    assign cmd_valid = stage_valid_reg;
    assign cmd_data  = stage_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (s_ready) begin
            stage_valid_reg <= s_valid && keep;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            stage_reg.is_query  <= (s_data.kind == nns_pkg::KIND_QUERY);
            stage_reg.node_slot <= s_data.node_slot;
            stage_reg.coord_x   <= s_data.coord_x;
            stage_reg.coord_y   <= s_data.coord_y;
            stage_reg.coord_z   <= s_data.coord_z;
        end
    end

endmodule

FILE: hdl/nns_queue.sv
// ----------------------------------------------------------------------------
// nns_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module nns_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  nns_pkg::cmd_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output nns_pkg::cmd_t out_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = 1;
    localparam int CNT_W = 2;

    nns_pkg::cmd_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

FILE: hdl/nns_back.sv
// ----------------------------------------------------------------------------
// nns_back
// Execution side: node store writes for loads, and for queries a pipelined
// walk over the store with a running minimum, ending in a result register.
// ----------------------------------------------------------------------------
module nns_back #(
    parameter int MAX_NODES = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [nns_pkg::DIMS_W-1:0]         dimensions,
    input  logic [nns_pkg::COUNT_W-1:0]        node_count,
    input  logic                               cmd_valid,
    output logic                               cmd_ready,
    input  nns_pkg::cmd_t                      cmd_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output nns_pkg::out_item_t                 m_data
);

    localparam int ADDR_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int STAGES = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // control
    state_t              state_reg,     state_next;
    logic [CNT_W-1:0]    count_reg,     count_next;
    logic [CNT_W-1:0]    addr_reg,      addr_next;
    logic [STAGES-1:0]   pipe_v_reg,    pipe_v_next;
    logic                found_reg,     found_next;
    logic [nns_pkg::SUM_W-1:0] best_reg, best_next;
    logic [ADDR_W-1:0]   best_idx_reg,  best_idx_next;
    logic                out_valid_reg, out_valid_next;
    nns_pkg::out_item_t  out_reg,       out_next;

    // datapath
    nns_pkg::node_t              node_mem [MAX_NODES];
    nns_pkg::node_t              rd_reg;
    nns_pkg::node_t              point_reg;
    logic [ADDR_W-1:0]           idx_pipe_reg [STAGES];
    logic [nns_pkg::COORD_BITS-1:0] absd_reg [nns_pkg::AXES];
    logic [nns_pkg::SQ_W-1:0]    sq_reg [nns_pkg::AXES];
    logic [nns_pkg::SUM_W-1:0]   sum_reg;

    logic [nns_pkg::COORD_BITS-1:0] node_ax  [nns_pkg::AXES];
    logic [nns_pkg::COORD_BITS-1:0] point_ax [nns_pkg::AXES];
    logic [nns_pkg::AXES-1:0]       axis_on;

    logic             cmd_take;
    logic             issue;
    logic             out_free;
    logic [CNT_W-1:0] sat_count;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign cmd_take  = cmd_valid && cmd_ready;
    assign issue     = (state_reg == ST_RUN) && (addr_reg != count_reg);
    assign out_free  = !out_valid_reg || m_ready;
    assign sat_count = (int'(node_count) > MAX_NODES) ? CNT_W'(MAX_NODES)
                                                      : CNT_W'(node_count);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    // dimensions of zero or one use the x axis alone
    assign axis_on = {dimensions == 2'd3, dimensions[1], 1'b1};

    assign node_ax[0]  = rd_reg.x;
    assign node_ax[1]  = rd_reg.y;
    assign node_ax[2]  = rd_reg.z;
    assign point_ax[0] = point_reg.x;
    assign point_ax[1] = point_reg.y;
    assign point_ax[2] = point_reg.z;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        addr_next      = addr_reg;
        pipe_v_next    = {pipe_v_reg[STAGES-2:0], issue};
        found_next     = found_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;

        // strict compare keeps the lowest index on ties
        if (pipe_v_reg[STAGES-1] && (!found_reg || sum_reg < best_reg)) begin
            found_next    = 1'b1;
            best_next     = sum_reg;
            best_idx_next = idx_pipe_reg[STAGES-1];
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_take && cmd_data.is_query) begin
                    state_next    = ST_RUN;
                    count_next    = sat_count;
                    addr_next     = '0;
                    found_next    = 1'b0;
                    best_next     = '0;
                    best_idx_next = '0;
                end
            end
            ST_RUN: begin
                if (issue) begin
                    addr_next = addr_reg + 1'b1;
                end else begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (pipe_v_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_valid_next            = 1'b1;
                    out_next.found            = found_reg;
                    out_next.nearest_index    = nns_pkg::IDX_W'(best_idx_reg);
                    out_next.squared_distance = nns_pkg::DIST_W'(best_reg);
                    state_next                = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            addr_reg      <= '0;
            pipe_v_reg    <= '0;
            found_reg     <= 1'b0;
            best_reg      <= '0;
            best_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            addr_reg      <= addr_next;
            pipe_v_reg    <= pipe_v_next;
            found_reg     <= found_next;
            best_reg      <= best_next;
            best_idx_reg  <= best_idx_next;
            out_valid_reg <= out_valid_next;
        end
        out_reg <= out_next;
    end

    // node store, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cmd_take && !cmd_data.is_query) begin
            node_mem[ADDR_W'(cmd_data.node_slot)] <=
                {cmd_data.coord_x, cmd_data.coord_y, cmd_data.coord_z};
        end
        if (issue) begin
            rd_reg <= node_mem[addr_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_take && cmd_data.is_query) begin
            point_reg <= {cmd_data.coord_x, cmd_data.coord_y, cmd_data.coord_z};
        end
        idx_pipe_reg[0] <= addr_reg[ADDR_W-1:0];
        for (int s = 1; s < STAGES; s++) begin
            idx_pipe_reg[s] <= idx_pipe_reg[s-1];
        end
        for (int a = 0; a < nns_pkg::AXES; a++) begin
            absd_reg[a] <= axis_on[a] ? nns_pkg::abs_diff(node_ax[a], point_ax[a]) : '0;
            sq_reg[a]   <= nns_pkg::SQ_W'(absd_reg[a]) * nns_pkg::SQ_W'(absd_reg[a]);
        end
        sum_reg <= nns_pkg::SUM_W'(sq_reg[0]) + nns_pkg::SUM_W'(sq_reg[1])
                 + nns_pkg::SUM_W'(sq_reg[2]);
    end

endmodule

FILE: hdl/nearest_node_search.sv
// ----------------------------------------------------------------------------
// nearest_node_search
// Brute-force nearest node search over a loaded node store, 1 to 3 axes.
// ----------------------------------------------------------------------------
// Load words write one node into the store in the cycle the back end takes
// them; loads aimed at a slot beyond MAX_NODES are dropped at the input.
// A query word walks nodes 0 to node_count-1 (node_count capped at
// MAX_NODES), reading one node per cycle from the single read port of the
// node store, each node passing through the read, difference, square, sum
// and compare stages before the result hand-off. Ties go to the lowest
// index; with no nodes the result has found low and zero index and
// distance. A two-entry queue between the input stage and the search
// engine keeps words flowing in while a search runs, and the result
// register lets the next search start before the previous result is
// taken. The store has no reset: reading a slot that was never loaded
// returns garbage. Write dimensions and node_count only while the block
// is idle.
module nearest_node_search #(
    parameter int MAX_NODES = 1024
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  nns_pkg::in_item_t                     s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output nns_pkg::out_item_t                    m_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [nns_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [nns_pkg::CFG_DATA_W-1:0]        cfg_data
);

    logic [nns_pkg::DIMS_W-1:0]  dims_reg;
    logic [nns_pkg::COUNT_W-1:0] node_count_reg;

    logic          fr_valid;
    logic          fr_ready;
    nns_pkg::cmd_t fr_data;
    logic          cmd_valid;
    logic          cmd_ready;
    nns_pkg::cmd_t cmd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg       <= nns_pkg::DIMS_RESET;
            node_count_reg <= nns_pkg::COUNT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                nns_pkg::REG_DIMENSIONS: begin
                    dims_reg <= cfg_data[nns_pkg::DIMS_W-1:0];
                end
                nns_pkg::REG_NODE_COUNT: begin
                    node_count_reg <= cfg_data[nns_pkg::COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    nns_front #(
        .MAX_NODES (MAX_NODES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (fr_valid),
        .cmd_ready (fr_ready),
        .cmd_data  (fr_data)
    );

    nns_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_data   (fr_data),
        .out_valid (cmd_valid),
        .out_ready (cmd_ready),
        .out_data  (cmd_data)
    );

    nns_back #(
        .MAX_NODES (MAX_NODES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .dimensions (dims_reg),
        .node_count (node_count_reg),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd_data   (cmd_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

`ifndef SYNTHESIS
    a_empty_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |->
            m_data.nearest_index == '0 && m_data.squared_distance == '0)
        else $error("empty search result carries nonzero fields");

    a_found_needs_nodes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.found |-> node_count_reg != '0)
        else $error("node reported found with node_count zero");

    a_query_blocks_back: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_valid && cmd_ready && cmd_data.is_query |=> !cmd_ready)
        else $error("search engine took a command while a query was running");
`endif

endmodule
